// ===== hw/rtl/lrmp_pkg.sv =====
// Shared types, constants and modular helpers for the recurrence-term unit.
// No dependencies; imported by lrmp_modmul, lrmp_engine and the top level.
package lrmp_pkg;

   localparam int unsigned ValueBits = 30;
   localparam logic [ValueBits-1:0] Modulus = 30'd1000000007;
   localparam logic [4:0] DigitLast = 5'd29;
   localparam logic [3:0] ElemLast = 4'd8;
   localparam logic [1:0] PosLast = 2'd2;
   localparam logic [1:0] RowCount = 2'd3;

   typedef logic [ValueBits-1:0] value_type;
   typedef logic [3:0] elem_type;
   typedef logic [1:0] pos_type;

   typedef struct packed {
      logic      idle;
      logic      done;
      value_type value;
   } eng_stat_type;

   function automatic value_type addmod(input value_type a, input value_type b);
      logic [ValueBits:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, Modulus}) begin
         sum = sum - {1'b0, Modulus};
      end
      return sum[ValueBits-1:0];
   endfunction

   function automatic elem_type elem_of(input pos_type r, input pos_type c);
      return ({2'b00, r} << 1) + {2'b00, r} + {2'b00, c};
   endfunction

   function automatic value_type companion(input elem_type e);
      value_type v;
      unique case (e)
         4'd0, 4'd1, 4'd5, 4'd6: v = value_type'(1);
         default:                v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/linear_recurrence_matrix_power_unit.sv =====
// Recurrence term unit: a(1)=a(2)=a(3)=1, a(n)=a(n-1)+a(n-3) mod 1000000007.
// Top level; depends on lrmp_pkg and lrmp_engine (which holds lrmp_modmul).
//
// Usage:
//   req_* carries one word per query, the term index n; rsp_* returns one word,
//   term n mod 1000000007. The unit works on one index at a time: req_tready is
//   high only while the engine is idle.
//   Indices of 3 or less give 1 without a multiply. Otherwise the companion
//   matrix is loaded and raised to the power n-3 by square-and-multiply.
//   Every multiply-accumulate runs through one bit-serial modular multiplier,
//   one bit per cycle. That multiplier sets the rate.
//   The result sits in an output register; the next index is taken while it
//   waits. If rsp_tready stays low, a finished result holds in the engine until
//   the output register frees.
//   Reset clears the engine and the output valid; nothing is kept between words.
module linear_recurrence_matrix_power_unit
   import lrmp_pkg::*;
#(
   parameter int INDEX_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] term_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [29:0] term_value, [31:30] zero
);

   localparam int WideBits = (INDEX_BITS > 32) ? INDEX_BITS : 32;

   logic [WideBits-1:0]   wide_index;
   logic [INDEX_BITS-1:0] term_index;
   logic                  accept;
   logic                  out_free;
   eng_stat_type          eng_stat;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   value_type             rsp_value_ff, rsp_value_in;

   assign wide_index = WideBits'(req_tdata);
   assign term_index = wide_index[INDEX_BITS-1:0];
   assign req_tready = eng_stat.idle;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   lrmp_engine #(
      .IndexBits (INDEX_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .index    (term_index),
      .out_free (out_free),
      .stat     (eng_stat)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_value_in  = rsp_value_ff;
      if (eng_stat.done) begin
         rsp_tvalid_in = 1'b1;
         rsp_value_in  = eng_stat.value;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_value_ff};

   a_accept_starts_engine: assert property (@(posedge clock) disable iff (reset)
      accept |=> !eng_stat.idle)
      else $error("accepted word did not start the engine");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_value_ff < Modulus))
      else $error("result word not reduced");

endmodule

// ===== hw/rtl/lrmp_modmul.sv =====
// Bit-serial modular multiplier: one bit of the first factor per cycle, MSB first.
// Depends on lrmp_pkg.
module lrmp_modmul
   import lrmp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  value_type a,
   input  value_type b,
   output logic      done,
   output value_type product
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   value_type         a_sr_ff, a_sr_in;
   value_type         b_ff, b_in;
   value_type         acc_ff, acc_in;
   logic [ValueBits:0] dbl;
   logic [ValueBits:0] dbl_red;

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, Modulus}) ? dbl - {1'b0, Modulus} : dbl;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_sr_in = a_sr_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_sr_in = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         // double, then add b when the current digit is set
         acc_in  = addmod(dbl_red[ValueBits-1:0], a_sr_ff[ValueBits-1] ? b_ff : '0);
         a_sr_in = a_sr_ff << 1;
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == DigitLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_sr_ff <= a_sr_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   a_product_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (acc_ff < Modulus))
      else $error("modmul product not reduced");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("modmul started while busy");

endmodule

// ===== hw/rtl/lrmp_engine.sv =====
// Square-and-multiply sequencer with banked matrix and row stores.
// Depends on lrmp_pkg and lrmp_modmul.
module lrmp_engine
   import lrmp_pkg::*;
#(
   parameter int IndexBits = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [IndexBits-1:0] index,
   input  logic                 out_free,
   output eng_stat_type         stat
);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_DECIDE, S_READ, S_START, S_MUL, S_NEXT, S_FETCH, S_OUT
   } state_type;

   typedef enum logic {MODE_SQR, MODE_VEC} mode_type;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [IndexBits-1:0] e_ff, e_in;
   elem_type             cnt_ff, cnt_in;
   pos_type              i_ff, i_in, j_ff, j_in, k_ff, k_in;
   value_type            sum_ff, sum_in;
   logic                 mbank_ff, mbank_in;
   logic                 rbank_ff, rbank_in;
   logic                 one_ff, one_in;

   value_type mat_mem [0:1][0:8];
   value_type row_mem [0:1][0:2];
   value_type rd_a_ff, rd_b_ff;

   logic      mat_we, row_we;
   logic      mat_wbank, row_wbank;
   elem_type  mat_welem;
   pos_type   row_wpos;
   value_type mat_wdata, row_wdata;
   elem_type  a_elem, b_elem;
   value_type acc;

   logic      mul_start, mul_done;
   value_type mul_product;

   lrmp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (rd_a_ff),
      .b       (rd_b_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   assign a_elem = elem_of(i_ff, k_ff);
   assign b_elem = elem_of(k_ff, j_ff);
   assign acc    = addmod(sum_ff, mul_product);

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      e_in      = e_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      sum_in    = sum_ff;
      mbank_in  = mbank_ff;
      rbank_in  = rbank_ff;
      one_in    = one_ff;
      mat_we    = 1'b0;
      row_we    = 1'b0;
      mat_wbank = 1'b0;
      row_wbank = 1'b0;
      mat_welem = cnt_ff;
      row_wpos  = cnt_ff[1:0];
      mat_wdata = companion(cnt_ff);
      row_wdata = value_type'(1);
      mul_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            one_in = 1'b0;
            if (start) begin
               if (index[IndexBits-1:2] == '0) begin
                  one_in   = 1'b1;
                  state_in = S_OUT;
               end else begin
                  e_in     = index - IndexBits'(3);
                  cnt_in   = '0;
                  mbank_in = 1'b0;
                  rbank_in = 1'b0;
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            // load companion matrix and the all-ones row into bank zero
            mat_we = 1'b1;
            row_we = (cnt_ff < {2'b00, RowCount});
            if (cnt_ff == ElemLast) begin
               state_in = S_DECIDE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_DECIDE: begin
            i_in   = '0;
            j_in   = '0;
            k_in   = '0;
            sum_in = '0;
            if (e_ff[0]) begin
               mode_in  = MODE_VEC;
               state_in = S_READ;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            e_in   = e_ff >> 1;
            i_in   = '0;
            j_in   = '0;
            k_in   = '0;
            sum_in = '0;
            if (e_ff[IndexBits-1:1] == '0) begin
               mode_in  = MODE_VEC;
               state_in = S_FETCH;
            end else begin
               mode_in  = MODE_SQR;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_START;
         end
         S_START: begin
            mul_start = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            if (mul_done) begin
               state_in = S_READ;
               if (k_ff == PosLast) begin
                  mat_wbank = ~mbank_ff;
                  mat_welem = elem_of(i_ff, j_ff);
                  mat_wdata = acc;
                  row_wbank = ~rbank_ff;
                  row_wpos  = j_ff;
                  row_wdata = acc;
                  mat_we    = (mode_ff == MODE_SQR);
                  row_we    = (mode_ff == MODE_VEC);
                  sum_in    = '0;
                  k_in      = '0;
                  if (j_ff == PosLast) begin
                     j_in = '0;
                     if (mode_ff == MODE_VEC) begin
                        rbank_in = ~rbank_ff;
                        state_in = S_NEXT;
                     end else if (i_ff == PosLast) begin
                        i_in     = '0;
                        mbank_in = ~mbank_ff;
                        state_in = S_DECIDE;
                     end else begin
                        i_in = i_ff + 2'd1;
                     end
                  end else begin
                     j_in = j_ff + 2'd1;
                  end
               end else begin
                  sum_in = acc;
                  k_in   = k_ff + 2'd1;
               end
            end
         end
         S_FETCH: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_SQR;
         one_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         one_ff   <= one_in;
      end
      e_ff     <= e_in;
      cnt_ff   <= cnt_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      sum_ff   <= sum_in;
      mbank_ff <= mbank_in;
      rbank_ff <= rbank_in;
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_wbank][mat_welem] <= mat_wdata;
      end
      if (row_we) begin
         row_mem[row_wbank][row_wpos] <= row_wdata;
      end
      rd_b_ff <= mat_mem[mbank_ff][b_elem];
      rd_a_ff <= (mode_ff == MODE_VEC) ? row_mem[rbank_ff][k_ff] : mat_mem[mbank_ff][a_elem];
   end

   assign stat.idle  = (state_ff == S_IDLE);
   assign stat.done  = (state_ff == S_OUT) && out_free;
   assign stat.value = one_ff ? value_type'(1) : rd_a_ff;

   a_mul_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("multiplier finished outside a multiply step");

endmodule
